// ===== rtl/core/dhcp_pkg.sv =====
// ----------------------------------------------------------------------------
// DHCP classifier package
// Shared constants, types and helper functions for the DHCP/BOOTP packet
// classifier.
// ----------------------------------------------------------------------------
package dhcp_pkg;

    localparam int unsigned POS_W = 8;
    localparam int unsigned PORT_W = 7;

    localparam logic [POS_W-1:0] OFS_OP = 8'd0;
    localparam logic [POS_W-1:0] OFS_HTYPE = 8'd1;
    localparam logic [POS_W-1:0] OFS_HOPS = 8'd3;
    localparam logic [POS_W-1:0] OFS_FLAGS_HI = 8'd10;
    localparam logic [POS_W-1:0] OFS_FLAGS_LO = 8'd11;
    localparam logic [POS_W-1:0] OFS_ADDR_FIRST = 8'd16;
    localparam logic [POS_W-1:0] OFS_ADDR_LAST = 8'd27;
    localparam logic [POS_W-1:0] OFS_COOKIE = 8'd236;
    localparam logic [POS_W-1:0] POS_SAT = 8'd240;
    localparam logic [POS_W-1:0] POS_MIN_LAST = 8'd43;
    localparam logic [POS_W-1:0] POS_COOKIE_LAST = 8'd239;

    localparam logic [7:0] OP_REQUEST = 8'd1;
    localparam logic [7:0] OP_REPLY = 8'd2;
    localparam logic [7:0] HTYPE_ETHERNET = 8'd1;
    localparam logic [7:0] FLAGS_BROADCAST_HI = 8'h80;
    localparam logic [31:0] BOOTP_COOKIE = 32'h63825363;

    localparam logic [PORT_W-1:0] DHCP_PORT = 7'd67;
    localparam logic [PORT_W-1:0] NO_PORT = 7'd0;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             rejected;
        logic             is_request;
        logic             cookie_bad;
    } t_pkt_state;

    typedef struct packed {
        logic rejected;
        logic is_request;
        logic cookie_bad;
    } t_chk_flags;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = BOOTP_COOKIE[31:24];
            2'd1: b = BOOTP_COOKIE[23:16];
            2'd2: b = BOOTP_COOKIE[15:8];
            2'd3: b = BOOTP_COOKIE[7:0];
            default: b = BOOTP_COOKIE[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/dhcp_stream_if.sv =====
// ----------------------------------------------------------------------------
// DHCP classifier stream interfaces
// Valid/ready channels for payload bytes in and port results out.
// ----------------------------------------------------------------------------
interface dhcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_udp;

    modport source (output valid, output data_byte, output last_byte, output is_udp,
                    input ready);
    modport sink (input valid, input data_byte, input last_byte, input is_udp,
                  output ready);
endinterface

interface dhcp_out_if;
    logic                          valid;
    logic                          ready;
    logic [dhcp_pkg::PORT_W-1:0]   port_result;

    modport source (output valid, output port_result, input ready);
    modport sink (input valid, input port_result, output ready);
endinterface

// ===== rtl/core/dhcp_hdr_check.sv =====
// ----------------------------------------------------------------------------
// DHCP header check
// Applies the fixed BOOTP header checks to one byte at its offset and
// returns the updated packet flags.
// ----------------------------------------------------------------------------
module dhcp_hdr_check (
    input  dhcp_pkg::t_pkt_state i_state,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_is_udp,
    output dhcp_pkg::t_chk_flags o_flags
);

    logic [dhcp_pkg::POS_W-1:0] pos;
    logic                       bad;
    logic                       cookie_miss;

    assign pos = i_state.pos;

    always_comb begin
        bad = 1'b0;
        cookie_miss = 1'b0;
        o_flags.is_request = i_state.is_request;
        if (pos == dhcp_pkg::OFS_OP) begin
            bad = (i_data_byte != dhcp_pkg::OP_REQUEST) && (i_data_byte != dhcp_pkg::OP_REPLY);
            o_flags.is_request = (i_data_byte == dhcp_pkg::OP_REQUEST);
        end else if (pos == dhcp_pkg::OFS_HTYPE) begin
            bad = (i_data_byte != dhcp_pkg::HTYPE_ETHERNET);
        end else if (pos == dhcp_pkg::OFS_HOPS) begin
            bad = (i_data_byte != 8'd0);
        end else if (pos == dhcp_pkg::OFS_FLAGS_HI) begin
            bad = (i_data_byte != dhcp_pkg::FLAGS_BROADCAST_HI) && (i_data_byte != 8'd0);
        end else if (pos == dhcp_pkg::OFS_FLAGS_LO) begin
            bad = (i_data_byte != 8'd0);
        end else if ((pos >= dhcp_pkg::OFS_ADDR_FIRST) && (pos <= dhcp_pkg::OFS_ADDR_LAST)) begin
            bad = i_state.is_request && (i_data_byte != 8'd0);
        end else if ((pos >= dhcp_pkg::OFS_COOKIE) && (pos < dhcp_pkg::POS_SAT)) begin
            cookie_miss = (i_data_byte != dhcp_pkg::cookie_byte(pos[1:0]));
        end
        o_flags.rejected = i_state.rejected || bad || !i_is_udp;
        o_flags.cookie_bad = i_state.cookie_bad || cookie_miss;
    end

endmodule

// ===== rtl/core/dhcp_packet_classifier.sv =====
// ----------------------------------------------------------------------------
// DHCP packet classifier
// Classifies a UDP payload as DHCP/BOOTP from its fixed header.
// ----------------------------------------------------------------------------
// The i_in channel carries one payload byte per word, from offset zero, with
// last_byte set on the final byte and is_udp held for the whole packet.
// The o_out channel carries one word per packet, port_result, which is 67
// when the header looks like DHCP and 0 otherwise. The options area after
// the magic cookie is not examined.
// One byte is taken per cycle while i_in.ready is high. The header checks
// run between the packet state registers and the result registers, so the
// result for a packet is registered as its final byte is accepted.
// Results pass through an output register with a one-word skid stage, so
// bytes keep flowing while a result waits; i_in.ready drops only when both
// hold a word, which takes a stall over two packet ends.
// Reset clears the packet state and empties both result stages.
// ----------------------------------------------------------------------------
module dhcp_packet_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dhcp_in_if.sink    i_in,
    dhcp_out_if.source o_out
);

    dhcp_pkg::t_pkt_state          r_state;
    dhcp_pkg::t_pkt_state          n_state;
    dhcp_pkg::t_chk_flags          chk_flags;
    logic                          r_out_valid;
    logic [dhcp_pkg::PORT_W-1:0]   r_out_port;
    logic                          r_skid_valid;
    logic [dhcp_pkg::PORT_W-1:0]   r_skid_port;
    logic                          in_take;
    logic                          push;
    logic                          pop;
    logic                          is_dhcp;
    logic [dhcp_pkg::PORT_W-1:0]   new_port;

    dhcp_hdr_check u_hdr_check (
        .i_state     (r_state),
        .i_data_byte (i_in.data_byte),
        .i_is_udp    (i_in.is_udp),
        .o_flags     (chk_flags)
    );

    assign i_in.ready = !r_skid_valid;
    assign in_take = i_in.valid && !r_skid_valid;
    assign push = in_take && i_in.last_byte;
    assign pop = r_out_valid && o_out.ready;

    assign is_dhcp = (r_state.pos >= dhcp_pkg::POS_MIN_LAST) && !chk_flags.rejected
                     && !((r_state.pos >= dhcp_pkg::POS_COOKIE_LAST) && chk_flags.cookie_bad);
    assign new_port = is_dhcp ? dhcp_pkg::DHCP_PORT : dhcp_pkg::NO_PORT;

    always_comb begin
        n_state = r_state;
        if (in_take) begin
            if (i_in.last_byte) begin
                n_state = '0;
            end else begin
                n_state.rejected = chk_flags.rejected;
                n_state.is_request = chk_flags.is_request;
                n_state.cookie_bad = chk_flags.cookie_bad;
                if (r_state.pos < dhcp_pkg::POS_SAT) begin
                    n_state.pos = r_state.pos + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (!r_out_valid || pop) begin
                r_out_valid <= r_skid_valid || push;
                r_skid_valid <= 1'b0;
            end else if (push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out_port <= r_skid_valid ? r_skid_port : new_port;
        end
        if (push && r_out_valid && !pop) begin
            r_skid_port <= new_port;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.port_result = r_out_port;

endmodule

// ===== rtl/core/dhcp_packet_classifier_chk.sv =====
// ----------------------------------------------------------------------------
// DHCP classifier port checker
// Watches the classifier's ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
module dhcp_packet_classifier_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last_byte,
    input logic                        i_in_is_udp,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dhcp_pkg::PORT_W-1:0] i_out_port
);

    logic in_last_take;

    assign in_last_take = i_in_valid && i_in_ready && i_in_last_byte;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_port)))
        else $error("result word dropped or changed while stalled");

    a_port_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_port == dhcp_pkg::DHCP_PORT) ||
                         (i_out_port == dhcp_pkg::NO_PORT)))
        else $error("result is neither the DHCP port nor zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && !in_last_take) |=> !i_out_valid)
        else $error("result appeared without a final byte");

    a_non_udp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_last_take && !i_in_is_udp && !i_out_valid) |=>
            (i_out_valid && (i_out_port == dhcp_pkg::NO_PORT)))
        else $error("non-UDP packet not reported as zero");

endmodule

bind dhcp_packet_classifier dhcp_packet_classifier_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last_byte (i_in.last_byte),
    .i_in_is_udp    (i_in.is_udp),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_port     (o_out.port_result)
);
